// ===== rtl/vqim_pkg.sv =====
// ----------------------------------------------------------------------------
// vqim_pkg
// Shared types and constants for the vertex quad id map.
// ----------------------------------------------------------------------------
package vqim_pkg;

   localparam int ID_BITS     = 13;   // width of a dense id
   localparam int ID_CNT_BITS = 14;   // id counter, holds the limit itself
   localparam int FILL_BITS   = 4;    // per-bucket fill count
   localparam int HASH_BITS   = 32;
   localparam int HASH_SHIFT  = 15;

   localparam logic [ID_CNT_BITS-1:0] ID_LIMIT  = ID_CNT_BITS'(8192);
   localparam logic [HASH_BITS-1:0]   HASH_MULT = 32'h9E37_79B1;

   localparam logic OP_GET_OR_INSERT = 1'b0;
   localparam logic OP_EXISTS        = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SORT,
      ST_HASH,
      ST_FILL,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_MAC,
      HS_MIX,
      HS_QUOT,
      HS_FOLD,
      HS_TRIM
   } hash_state_type;

endpackage

// ===== rtl/vqim_req_if.sv =====
// ----------------------------------------------------------------------------
// vqim_req_if
// Request channel: opcode, four unordered vertex indices and a tag.
// ----------------------------------------------------------------------------
interface vqim_req_if #(
   parameter int VERTEX_BITS = 24,
   parameter int TAG_BITS    = 8
);
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [VERTEX_BITS-1:0] vertex_a;
   logic [VERTEX_BITS-1:0] vertex_b;
   logic [VERTEX_BITS-1:0] vertex_c;
   logic [VERTEX_BITS-1:0] vertex_d;
   logic [TAG_BITS-1:0]    dof_tag;

   modport source (
      output valid, opcode, vertex_a, vertex_b, vertex_c, vertex_d, dof_tag,
      input  ready
   );
   modport sink (
      input  valid, opcode, vertex_a, vertex_b, vertex_c, vertex_d, dof_tag,
      output ready
   );
endinterface

// ===== rtl/vqim_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vqim_rsp_if
// Response channel: dense id, presence and table-full flags.
// ----------------------------------------------------------------------------
interface vqim_rsp_if;
   import vqim_pkg::*;

   logic               valid;
   logic               ready;
   logic [ID_BITS-1:0] entry_id;
   logic               was_present;
   logic               table_full;

   modport source (output valid, entry_id, was_present, table_full, input ready);
   modport sink   (input valid, entry_id, was_present, table_full, output ready);
endinterface

// ===== rtl/vqim_hash_unit.sv =====
// ----------------------------------------------------------------------------
// vqim_hash_unit
// Iterative key hash: one 32-bit multiply-add per cycle over the sorted
// vertices, a xor-shift mix, then the bucket (mask, or a reciprocal
// reduction on the same multiplier).
// ----------------------------------------------------------------------------
module vqim_hash_unit #(
   parameter int NUM_BUCKETS = 1024,
   parameter int VERTEX_BITS = 24,
   parameter int TAG_BITS    = 8,
   localparam int BKT_W      = $clog2(NUM_BUCKETS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [TAG_BITS-1:0]         tag,
   input  logic [3:0][VERTEX_BITS-1:0] vertices,
   output logic                        done,
   output logic [BKT_W-1:0]            bucket
);
   import vqim_pkg::*;

   localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
   localparam logic [HASH_BITS-1:0] MODULUS = HASH_BITS'(NUM_BUCKETS);
   // floor(2^32 / NUM_BUCKETS): the quotient estimate is low by at most one
   localparam logic [HASH_BITS-1:0] RECIP =
      HASH_BITS'((64'd1 << HASH_BITS) / NUM_BUCKETS);

   hash_state_type          state_ff, state_in;
   logic [HASH_BITS-1:0]    h_ff, h_in;
   logic [HASH_BITS-1:0]    quot_ff, quot_in;
   logic [1:0]              step_ff, step_in;
   logic [BKT_W-1:0]        bucket_ff, bucket_in;
   logic                    done_ff, done_in;

   logic [HASH_BITS-1:0]    mixed;
   logic [HASH_BITS-1:0]    mul_a;
   logic [HASH_BITS-1:0]    mul_b;
   logic [2*HASH_BITS-1:0]  product;

   assign mixed = h_ff ^ (h_ff >> HASH_SHIFT);

   // the one shared multiplier
   assign mul_a   = (state_ff == HS_FOLD) ? quot_ff : h_ff;
   assign mul_b   = (state_ff == HS_QUOT) ? RECIP :
                    (state_ff == HS_FOLD) ? MODULUS : HASH_MULT;
   assign product = (2*HASH_BITS)'(mul_a) * (2*HASH_BITS)'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      h_ff      <= h_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      bucket_ff <= bucket_in;
   end

   always_comb begin
      state_in  = state_ff;
      h_in      = h_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      bucket_in = bucket_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         HS_IDLE: begin
            if (start) begin
               h_in     = HASH_BITS'(tag);
               step_in  = 2'd0;
               state_in = HS_MAC;
            end
         end
         HS_MAC: begin
            h_in    = product[HASH_BITS-1:0] + HASH_BITS'(vertices[step_ff]);
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = HS_MIX;
            end
         end
         HS_MIX: begin
            if (IS_POW2) begin
               bucket_in = mixed[BKT_W-1:0];
               done_in   = 1'b1;
               state_in  = HS_IDLE;
            end else begin
               h_in     = mixed;
               state_in = HS_QUOT;
            end
         end
         HS_QUOT: begin
            quot_in  = product[2*HASH_BITS-1:HASH_BITS];
            state_in = HS_FOLD;
         end
         HS_FOLD: begin
            // remainder before the final correction, below twice the modulus
            h_in     = h_ff - product[HASH_BITS-1:0];
            state_in = HS_TRIM;
         end
         HS_TRIM: begin
            bucket_in = (h_ff >= MODULUS) ? BKT_W'(h_ff - MODULUS) : BKT_W'(h_ff);
            done_in   = 1'b1;
            state_in  = HS_IDLE;
         end
         default: state_in = HS_IDLE;
      endcase
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

// ===== rtl/vertex_quad_id_map_top.sv =====
// ----------------------------------------------------------------------------
// vertex_quad_id_map_top
// Dense id assignment for unordered vertex quadruples plus a tag.
//
// Request channel (req_if): opcode, four vertex indices, dof tag. The four
// indices are sorted, the key is hashed into a bucket and the filled ways of
// that bucket are scanned for an exact match. Get-or-insert returns the
// stored id or stores the key with the next id; exists only reports.
// Response channel (rsp_if): entry_id, was_present, table_full, one per item.
//
// Timing: one item at a time. An accepted item passes sort, hash, fill
// read, a scan of the filled ways and, on a miss, the decide step; the
// 32-bit multiply-add of the hash (four passes) and the single-port slot
// memory scan dominate. A bucket count that is not a power of two adds a
// reciprocal reduction. Reset: bucket fill counts are cleared by a pass
// over all buckets, one per cycle; req_if.ready stays low until it completes.
// The next item is taken while a result waits in the output register; if
// rsp_if is stalled, the finished result of that item waits for it.
// ----------------------------------------------------------------------------
module vertex_quad_id_map_top #(
   parameter int NUM_BUCKETS = 1024,
   parameter int BUCKET_WAYS = 8,
   parameter int VERTEX_BITS = 24,
   parameter int TAG_BITS    = 8
) (
   input logic         clock,
   input logic         reset,
   vqim_req_if.sink    req_if,
   vqim_rsp_if.source  rsp_if
);
   import vqim_pkg::*;

   localparam int BKT_W   = $clog2(NUM_BUCKETS);
   localparam int SLOTS   = NUM_BUCKETS * BUCKET_WAYS;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int KEY_W   = 4 * VERTEX_BITS + TAG_BITS;
   localparam int SLOT_DW = ID_BITS + KEY_W;
   localparam logic [FILL_BITS-1:0] WAYS = FILL_BITS'(BUCKET_WAYS);
   localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(NUM_BUCKETS - 1);

   state_type state_ff, state_in;

   logic                        op_ff, op_in;
   logic [3:0][VERTEX_BITS-1:0] vin_ff, vin_in;
   logic [TAG_BITS-1:0]         tag_ff, tag_in;
   logic [3:0][VERTEX_BITS-1:0] sorted_ff, sorted_in;
   logic [KEY_W-1:0]            key_ff, key_in;
   logic [BKT_W-1:0]            clr_ff, clr_in;
   logic [FILL_BITS-1:0]        fill_ff, fill_in;
   logic [SLOT_W-1:0]           base_ff, base_in;
   logic [FILL_BITS-1:0]        way_ff, way_in;
   logic                        pend_ff, pend_in;
   logic [ID_CNT_BITS-1:0]      next_id_ff, next_id_in;
   logic [ID_BITS-1:0]          res_id_ff, res_id_in;
   logic                        res_present_ff, res_present_in;
   logic                        res_full_ff, res_full_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]          rsp_id_ff, rsp_id_in;
   logic                        rsp_present_ff, rsp_present_in;
   logic                        rsp_full_ff, rsp_full_in;

   // memories
   logic [FILL_BITS-1:0] fill_mem [NUM_BUCKETS];
   logic [FILL_BITS-1:0] fill_q;
   logic                 fill_we;
   logic [BKT_W-1:0]     fill_waddr;
   logic [FILL_BITS-1:0] fill_wdata;
   logic [SLOT_DW-1:0]   slot_mem [SLOTS];
   logic [SLOT_DW-1:0]   slot_q;
   logic                 slot_we;
   logic [SLOT_W-1:0]    slot_addr;
   logic [SLOT_DW-1:0]   slot_wdata;

   logic                 hash_start;
   logic                 hash_done;
   logic [BKT_W-1:0]     bucket;
   logic                 req_take;
   logic                 rsp_free;
   logic                 hit;

   vqim_hash_unit #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .VERTEX_BITS (VERTEX_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .tag      (tag_ff),
      .vertices (sorted_ff),
      .done     (hash_done),
      .bucket   (bucket)
   );

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_q <= fill_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_addr] <= slot_wdata;
      end
      slot_q <= slot_mem[slot_addr];
   end

   // four-input sorting network, ascending
   always_comb begin
      logic [VERTEX_BITS-1:0] s0, s1, s2, s3, t;
      t  = '0;
      s0 = vin_ff[0];
      s1 = vin_ff[1];
      s2 = vin_ff[2];
      s3 = vin_ff[3];
      if (s0 > s1) begin t = s0; s0 = s1; s1 = t; end
      if (s2 > s3) begin t = s2; s2 = s3; s3 = t; end
      if (s0 > s2) begin t = s0; s0 = s2; s2 = t; end
      if (s1 > s3) begin t = s1; s1 = s3; s3 = t; end
      if (s1 > s2) begin t = s1; s1 = s2; s2 = t; end
      sorted_in = {s3, s2, s1, s0};
   end

   assign req_take   = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign hit        = pend_ff && (slot_q[KEY_W-1:0] == key_ff);
   assign req_if.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff          <= op_in;
      vin_ff         <= vin_in;
      tag_ff         <= tag_in;
      sorted_ff      <= (state_ff == ST_SORT) ? sorted_in : sorted_ff;
      key_ff         <= key_in;
      fill_ff        <= fill_in;
      base_ff        <= base_in;
      way_ff         <= way_in;
      res_id_ff      <= res_id_in;
      res_present_ff <= res_present_in;
      res_full_ff    <= res_full_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_present_ff <= rsp_present_in;
      rsp_full_ff    <= rsp_full_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      vin_in         = vin_ff;
      tag_in         = tag_ff;
      key_in         = key_ff;
      clr_in         = clr_ff;
      fill_in        = fill_ff;
      base_in        = base_ff;
      way_in         = way_ff;
      pend_in        = pend_ff;
      next_id_in     = next_id_ff;
      res_id_in      = res_id_ff;
      res_present_in = res_present_ff;
      res_full_in    = res_full_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_id_in      = rsp_id_ff;
      rsp_present_in = rsp_present_ff;
      rsp_full_in    = rsp_full_ff;
      fill_we        = 1'b0;
      fill_waddr     = bucket;
      fill_wdata     = fill_ff + FILL_BITS'(1);
      slot_we        = 1'b0;
      slot_addr      = base_ff + SLOT_W'(way_ff);
      slot_wdata     = {next_id_ff[ID_BITS-1:0], key_ff};
      hash_start     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + BKT_W'(1);
            if (clr_ff == LAST_BUCKET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in    = req_if.opcode;
               vin_in   = {req_if.vertex_d, req_if.vertex_c,
                           req_if.vertex_b, req_if.vertex_a};
               tag_in   = req_if.dof_tag;
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            key_in     = {tag_ff, sorted_in};
            hash_start = 1'b1;
            state_in   = ST_HASH;
         end
         ST_HASH: begin
            // fill count of the bucket is read on the done cycle
            if (hash_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            fill_in  = (fill_q > WAYS) ? WAYS : fill_q;
            base_in  = SLOT_W'(bucket) * SLOT_W'(BUCKET_WAYS);
            way_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // read of way n overlaps the compare of way n-1
            if (hit) begin
               res_id_in      = slot_q[SLOT_DW-1 -: ID_BITS];
               res_present_in = 1'b1;
               res_full_in    = 1'b0;
               pend_in        = 1'b0;
               state_in       = ST_DONE;
            end else if (way_ff < fill_ff) begin
               way_in  = way_ff + FILL_BITS'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_id_in      = '0;
            res_present_in = 1'b0;
            res_full_in    = 1'b0;
            slot_addr      = base_ff + SLOT_W'(fill_ff);
            if (op_ff == OP_GET_OR_INSERT) begin
               if (fill_ff >= WAYS || next_id_ff >= ID_LIMIT) begin
                  res_full_in = 1'b1;
               end else begin
                  slot_we    = 1'b1;
                  fill_we    = 1'b1;
                  res_id_in  = next_id_ff[ID_BITS-1:0];
                  next_id_in = next_id_ff + ID_CNT_BITS'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_id_in      = res_id_ff;
               rsp_present_in = res_present_ff;
               rsp_full_in    = res_full_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.entry_id    = rsp_id_ff;
   assign rsp_if.was_present = rsp_present_ff;
   assign rsp_if.table_full  = rsp_full_ff;

   // ---------------------------------------------------------------- checks
   a_id_bounded: assert property (@(posedge clock) disable iff (reset)
      next_id_ff <= ID_LIMIT)
      else $error("id counter beyond limit");

   a_id_moves_on_insert: assert property (@(posedge clock) disable iff (reset)
      (next_id_ff != $past(next_id_ff)) |-> ($past(state_ff) == ST_DECIDE))
      else $error("id counter changed outside an insert");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_present_ff && rsp_full_ff))
      else $error("result both present and full");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (fill_q <= WAYS))
      else $error("bucket fill count beyond way count");

endmodule

// ===== bench/vertex_quad_id_map_top_test.sv =====
// ----------------------------------------------------------------------------
// vertex_quad_id_map_top_test
// Self-checking bench for the vertex quad id map. A queue-fed driver offers
// get-or-insert and exists items; a monitor predicts each result from its own
// copy of the table (sorted key, bucket hash, per-bucket fill, id counter) and
// compares every response field in order. The run covers directed corner
// items, random items under four idle/stall mixes with one long output
// hold-off, and late lookups of new keys and of the first keys stored.
// ----------------------------------------------------------------------------
module vertex_quad_id_map_top_test;
   import vqim_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUCKETS     = 1024;
   localparam int WAYS        = 8;
   localparam int VERTEX_BITS = 24;
   localparam int TAG_BITS    = 8;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int KEY_BITS    = 4 * VERTEX_BITS + TAG_BITS;

   localparam int RANDOM_PER_PHASE = 350;
   localparam int HOLD_CYCLES      = 400;
   // clear pass (one cycle per bucket) and the long hold-off dominate
   localparam int WATCHDOG_LIMIT   = 4000;

   localparam logic [VERTEX_BITS-1:0] VTX_MAX = '1;
   localparam logic [TAG_BITS-1:0]    TAG_MAX = '1;

   typedef struct packed {
      logic                   opcode;
      logic [VERTEX_BITS-1:0] vertex_a;
      logic [VERTEX_BITS-1:0] vertex_b;
      logic [VERTEX_BITS-1:0] vertex_c;
      logic [VERTEX_BITS-1:0] vertex_d;
      logic [TAG_BITS-1:0]    dof_tag;
   } quad_req_type;

   // vtx[0] is the smallest vertex
   typedef struct packed {
      logic [3:0][VERTEX_BITS-1:0] vtx;
      logic [TAG_BITS-1:0]         tag;
   } quad_key_type;

   typedef struct packed {
      logic [ID_BITS-1:0] entry_id;
      logic               was_present;
      logic               table_full;
   } id_result_type;

   bit clock;
   bit reset;

   vqim_req_if #(.VERTEX_BITS(VERTEX_BITS), .TAG_BITS(TAG_BITS)) req_bus ();
   vqim_rsp_if rsp_bus ();

   vertex_quad_id_map_top #(
      .NUM_BUCKETS (BUCKETS),
      .BUCKET_WAYS (WAYS),
      .VERTEX_BITS (VERTEX_BITS),
      .TAG_BITS    (TAG_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #4 clock = ~clock;

   // predicted table contents
   logic [ID_BITS-1:0]     id_of_key [logic [KEY_BITS-1:0]];
   logic [FILL_BITS-1:0]   bucket_load [BUCKETS];
   logic [ID_CNT_BITS-1:0] next_id;

   quad_req_type  req_backlog [$];
   id_result_type expected_ids [$];
   quad_key_type  key_pool [$];

   int  items_queued, items_taken, mismatch_count, hit_count, full_count;
   int  quiet_cycles;
   int  send_idle_pct, recv_stall_pct;
   int  hold_left;
   bit  hold_start;
   bit  req_fire;

   function automatic quad_key_type sorted_key(quad_req_type r);
      logic [VERTEX_BITS-1:0] v [4];
      logic [VERTEX_BITS-1:0] t;
      quad_key_type k;
      v[0] = r.vertex_a;
      v[1] = r.vertex_b;
      v[2] = r.vertex_c;
      v[3] = r.vertex_d;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3 - i; j++)
            if (v[j] > v[j+1]) begin
               t      = v[j];
               v[j]   = v[j+1];
               v[j+1] = t;
            end
      for (int i = 0; i < 4; i++) k.vtx[i] = v[i];
      k.tag = r.dof_tag;
      return k;
   endfunction

   function automatic logic [BUCKET_BITS-1:0] bucket_index(quad_key_type k);
      logic [HASH_BITS-1:0] h;
      h = HASH_BITS'(k.tag);
      for (int i = 0; i < 4; i++) h = h * HASH_MULT + HASH_BITS'(k.vtx[i]);
      h = h ^ (h >> HASH_SHIFT);
      return BUCKET_BITS'(h % BUCKETS);
   endfunction

   function automatic id_result_type predict_dense_id(quad_req_type r);
      quad_key_type            k;
      logic [BUCKET_BITS-1:0]  b;
      id_result_type           res;
      k   = sorted_key(r);
      b   = bucket_index(k);
      res = '0;
      if (id_of_key.exists(k)) begin
         res.entry_id    = id_of_key[k];
         res.was_present = 1'b1;
      end else if (r.opcode == OP_GET_OR_INSERT) begin
         if (bucket_load[b] >= WAYS || next_id >= ID_LIMIT) begin
            res.table_full = 1'b1;
         end else begin
            id_of_key[k]   = next_id[ID_BITS-1:0];
            bucket_load[b] = bucket_load[b] + 1'b1;
            res.entry_id   = next_id[ID_BITS-1:0];
            next_id        = next_id + 1'b1;
         end
      end
      return res;
   endfunction

   function automatic quad_req_type make_req(logic op, logic [VERTEX_BITS-1:0] a,
                                             logic [VERTEX_BITS-1:0] b,
                                             logic [VERTEX_BITS-1:0] c,
                                             logic [VERTEX_BITS-1:0] d,
                                             logic [TAG_BITS-1:0] tag);
      quad_req_type r;
      r.opcode   = op;
      r.vertex_a = a;
      r.vertex_b = b;
      r.vertex_c = c;
      r.vertex_d = d;
      r.dof_tag  = tag;
      return r;
   endfunction

   // key presented in a random vertex order
   function automatic quad_req_type shuffled_req(quad_key_type k, logic op);
      logic [VERTEX_BITS-1:0] v [4];
      logic [VERTEX_BITS-1:0] t;
      int j;
      for (int i = 0; i < 4; i++) v[i] = k.vtx[i];
      for (int i = 3; i > 0; i--) begin
         j    = $urandom_range(i);
         t    = v[i];
         v[i] = v[j];
         v[j] = t;
      end
      return make_req(op, v[0], v[1], v[2], v[3], k.tag);
   endfunction

   function automatic quad_key_type wide_key();
      quad_key_type k;
      for (int i = 0; i < 4; i++) k.vtx[i] = VERTEX_BITS'($urandom);
      k.tag = TAG_BITS'($urandom);
      return k;
   endfunction

   // mix of wide values, small and near-max values and repeated vertices
   function automatic quad_key_type fresh_key();
      quad_key_type k;
      k = wide_key();
      for (int i = 0; i < 4; i++)
         case ($urandom_range(9))
            0: k.vtx[i] = VERTEX_BITS'($urandom_range(3));
            1: k.vtx[i] = VTX_MAX - VERTEX_BITS'($urandom_range(3));
            2: if (i > 0) k.vtx[i] = k.vtx[i-1];
            default: ;
         endcase
      case ($urandom_range(9))
         0: k.tag = '0;
         1: k.tag = TAG_MAX;
         default: ;
      endcase
      return k;
   endfunction

   // reuse of known keys (hits), near misses, and new keys
   function automatic quad_req_type random_item();
      quad_key_type k;
      int           pick;
      logic         op;
      pick = $urandom_range(99);
      op   = ($urandom_range(99) < 35) ? OP_EXISTS : OP_GET_OR_INSERT;
      if (key_pool.size() == 0 || pick >= 60) begin
         k = fresh_key();
         key_pool = {key_pool, k};
      end else begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
         if (pick >= 48) begin
            if ($urandom_range(1))
               k.tag = k.tag ^ TAG_BITS'(1 << $urandom_range(TAG_BITS - 1));
            else
               k.vtx[$urandom_range(3)] = k.vtx[$urandom_range(3)]
                                        ^ VERTEX_BITS'(1 << $urandom_range(VERTEX_BITS - 1));
            key_pool = {key_pool, k};
         end
      end
      return shuffled_req(k, op);
   endfunction

   task automatic queue_item(quad_req_type r);
      req_backlog = {req_backlog, r};
      items_queued++;
   endtask

   // returns on a rising edge once every queued item has its result
   task automatic wait_idle();
      do @(negedge clock);
      while (items_taken != items_queued || expected_ids.size() != 0);
      @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_requests
      quad_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = req_backlog.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.opcode   <= nxt.opcode;
            req_bus.vertex_a <= nxt.vertex_a;
            req_bus.vertex_b <= nxt.vertex_b;
            req_bus.vertex_c <= nxt.vertex_c;
            req_bus.vertex_d <= nxt.vertex_d;
            req_bus.dof_tag  <= nxt.dof_tag;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_start) begin
         hold_start     = 1'b0;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_channels
      id_result_type want;
      bit            in_fire, out_fire;
      in_fire  = !reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
      out_fire = !reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1;
      req_fire     <= in_fire;
      quiet_cycles <= (reset || in_fire || out_fire) ? 0 : quiet_cycles + 1;
      if (in_fire) begin
         expected_ids = {expected_ids, predict_dense_id(make_req(req_bus.opcode,
            req_bus.vertex_a, req_bus.vertex_b, req_bus.vertex_c, req_bus.vertex_d,
            req_bus.dof_tag))};
         items_taken++;
      end
      if (out_fire) begin
         if (expected_ids.size() == 0) begin
            $display("%0t: result with no item outstanding: id %0d present %0b full %0b",
                     $time, rsp_bus.entry_id, rsp_bus.was_present, rsp_bus.table_full);
            mismatch_count++;
         end else begin
            want = expected_ids.pop_front();
            if (rsp_bus.entry_id !== want.entry_id) begin
               $display("%0t: entry_id expected %0d, actual %0d",
                        $time, want.entry_id, rsp_bus.entry_id);
               mismatch_count++;
            end
            if (rsp_bus.was_present !== want.was_present) begin
               $display("%0t: was_present expected %0b, actual %0b",
                        $time, want.was_present, rsp_bus.was_present);
               mismatch_count++;
            end
            if (rsp_bus.table_full !== want.table_full) begin
               $display("%0t: table_full expected %0b, actual %0b",
                        $time, want.table_full, rsp_bus.table_full);
               mismatch_count++;
            end
            hit_count  += want.was_present;
            full_count += want.table_full;
         end
      end
   end

   initial begin : watchdog
      do @(negedge clock);
      while (quiet_cycles < WATCHDOG_LIMIT);
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("vertex_quad_id_map_top test failed");
      $finish;
   end

   initial begin : run_stimulus
      quad_key_type           crowd [9];
      logic [BUCKET_BITS-1:0] target;
      int                     send_mix [4];
      int                     recv_mix [4];

      send_mix         = '{0, 79, 0, 38};
      recv_mix         = '{0, 0, 79, 38};
      reset            = 1'b1;
      next_id          = '0;
      foreach (bucket_load[i]) bucket_load[i] = '0;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_GET_OR_INSERT;
      req_bus.vertex_a = '0;
      req_bus.vertex_b = '0;
      req_bus.vertex_c = '0;
      req_bus.vertex_d = '0;
      req_bus.dof_tag  = '0;
      rsp_bus.ready    = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // directed: field extremes, vertex order, tag as part of the key
      queue_item(make_req(OP_EXISTS, '0, '0, '0, '0, '0));
      queue_item(make_req(OP_GET_OR_INSERT, '0, '0, '0, '0, '0));
      queue_item(make_req(OP_GET_OR_INSERT, VTX_MAX, VTX_MAX, VTX_MAX, VTX_MAX, TAG_MAX));
      queue_item(make_req(OP_EXISTS, VTX_MAX, VTX_MAX, VTX_MAX, VTX_MAX, TAG_MAX));
      queue_item(make_req(OP_GET_OR_INSERT, 24'h800000, 24'h000005, 24'hFFFFFF,
                          24'h123456, 8'h80));
      queue_item(make_req(OP_GET_OR_INSERT, 24'hFFFFFF, 24'h123456, 24'h800000,
                          24'h000005, 8'h80));
      queue_item(make_req(OP_EXISTS, 24'h000005, 24'h123456, 24'hFFFFFF,
                          24'h800000, 8'h80));
      queue_item(make_req(OP_EXISTS, 24'h000005, 24'h123456, 24'hFFFFFF,
                          24'h800000, 8'h81));
      queue_item(make_req(OP_GET_OR_INSERT, 24'h123456, 24'h000005, 24'hFFFFFF,
                          24'h800000, 8'h81));
      queue_item(make_req(OP_GET_OR_INSERT, '0, '0, '0, '0, '0));

      // nine keys in one bucket: eight fit, the ninth finds the bucket full
      target = bucket_index(wide_key());
      for (int i = 0; i < 9; i++) begin
         do crowd[i] = wide_key();
         while (bucket_index(crowd[i]) != target);
         queue_item(shuffled_req(crowd[i], OP_GET_OR_INSERT));
      end
      queue_item(shuffled_req(crowd[8], OP_EXISTS));
      queue_item(shuffled_req(crowd[8], OP_GET_OR_INSERT));
      queue_item(shuffled_req(crowd[0], OP_GET_OR_INSERT));
      queue_item(shuffled_req(crowd[7], OP_EXISTS));
      wait_idle();

      // random items; the first mix starts with a long output hold-off
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_mix[p];
         recv_stall_pct = recv_mix[p];
         if (p == 0) hold_start = 1'b1;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_item(random_item());
         wait_idle();
      end

      // late lookups: new keys, and keys stored at the start still found
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_item(shuffled_req(wide_key(), OP_GET_OR_INSERT));
      queue_item(make_req(OP_GET_OR_INSERT, '0, '0, '0, '0, '0));
      queue_item(make_req(OP_EXISTS, VTX_MAX, VTX_MAX, VTX_MAX, VTX_MAX, TAG_MAX));
      queue_item(shuffled_req(wide_key(), OP_EXISTS));
      wait_idle();
      repeat (40) @(posedge clock);

      $display("covered %0d items: %0d ids handed out, %0d found present, %0d refused",
               items_taken, next_id, hit_count, full_count);
      $display("mixes: no idle, sender idle, receiver stall, both; one %0d-cycle hold-off",
               HOLD_CYCLES);
      if (mismatch_count == 0 && expected_ids.size() == 0) begin
         $display("vertex_quad_id_map_top test passed");
      end else begin
         $display("vertex_quad_id_map_top test failed");
      end
      $finish;
   end

endmodule
